### hw/rtl/depq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// depq_pkg
// shared types and constants for the double-ended priority queue
// ---------------------------------------------------------------------------
package depq_pkg;

  localparam int DEPQ_CAPACITY = 256;
  localparam int DATA_W        = 32;

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_DEL_MIN = 2'd1,
    ACT_DEL_MAX = 2'd2,
    ACT_FINISH  = 2'd3
  } action_e;

endpackage

### hw/rtl/double_ended_priority_queue_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// double_ended_priority_queue_top
// bounded sorted multiset of signed values kept in a circular memory
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_stall_o  action_i, value_i
//   out      output     out_valid_o / out_stall_i is_empty_o, max_value_o,
//                                                min_value_o, insert_dropped_o,
//                                                delete_ignored_o
//
// delete, finish and a dropped insert go straight to the min/max read-back
// (RMIN, RMAX, RLAST); an insert first runs a shift loop (INS_RD, INS_CMP)
// over the single memory read port that moves up each held value greater
// than the new one.
// reset empties the set at once; no clearing pass.
// out stall holds the finished transaction in the output register.
// ---------------------------------------------------------------------------
module double_ended_priority_queue_top import depq_pkg::*; #(
  parameter int Capacity = DEPQ_CAPACITY
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               action_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     is_empty_o,
  output logic signed [DATA_W-1:0] max_value_o,
  output logic signed [DATA_W-1:0] min_value_o,
  output logic                     insert_dropped_o,
  output logic                     delete_ignored_o
);

  localparam int AW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int CW = $clog2(Capacity + 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS_RD  = 3'd1;
  localparam logic [2:0] S_INS_CMP = 3'd2;
  localparam logic [2:0] S_RMIN    = 3'd3;
  localparam logic [2:0] S_RMAX    = 3'd4;
  localparam logic [2:0] S_RLAST   = 3'd5;

  logic [2:0]               state_q, state_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic [AW-1:0]            head_q, head_d;
  logic [CW-1:0]            idx_q, idx_d;
  logic signed [DATA_W-1:0] key_q, key_d;
  logic                     drop_q, drop_d;
  logic                     ign_q, ign_d;
  logic                     clr_q, clr_d;
  logic [DATA_W-1:0]        min_q, min_d;

  logic                     ov_q, ov_d;
  logic                     oe_q, oe_d;
  logic [DATA_W-1:0]        omax_q, omax_d;
  logic [DATA_W-1:0]        omin_q, omin_d;
  logic                     odr_q, odr_d;
  logic                     oig_q, oig_d;

  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [DATA_W-1:0] wdata, rdata;
  logic              in_acc, out_acc, load;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] j);
    logic [CW:0] s;
    s = {{(CW + 1 - AW){1'b0}}, h} + {1'b0, j};
    if (s >= (CW + 1)'(Capacity)) begin
      s = s - (CW + 1)'(Capacity);
    end
    return s[AW-1:0];
  endfunction

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = ov_q && !out_stall_i;
  assign load       = (state_q == S_RLAST) && (!ov_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    head_d  = head_q;
    idx_d   = idx_q;
    key_d   = key_q;
    drop_d  = drop_q;
    ign_d   = ign_q;
    clr_d   = clr_q;
    min_d   = min_q;
    we      = 1'b0;
    waddr   = '0;
    wdata   = key_q;
    re      = 1'b0;
    raddr   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          key_d   = value_i;
          drop_d  = 1'b0;
          ign_d   = 1'b0;
          clr_d   = 1'b0;
          state_d = S_RMIN;
          case (action_i)
            ACT_INSERT: begin
              if (cnt_q == CW'(Capacity)) begin
                drop_d = 1'b1;
              end else begin
                idx_d   = cnt_q;
                state_d = S_INS_RD;
              end
            end
            ACT_DEL_MIN: begin
              if (cnt_q == '0) begin
                ign_d = 1'b1;
              end else begin
                cnt_d  = cnt_q - 1'b1;
                head_d = (head_q == AW'(Capacity - 1)) ? '0 : head_q + 1'b1;
              end
            end
            ACT_DEL_MAX: begin
              if (cnt_q == '0) begin
                ign_d = 1'b1;
              end else begin
                cnt_d = cnt_q - 1'b1;
              end
            end
            default: begin
              clr_d = 1'b1;
            end
          endcase
        end
      end
      S_INS_RD: begin
        if (idx_q == '0) begin
          we      = 1'b1;
          waddr   = phys(head_q, '0);
          wdata   = key_q;
          cnt_d   = cnt_q + 1'b1;
          state_d = S_RMIN;
        end else begin
          re      = 1'b1;
          raddr   = phys(head_q, idx_q - 1'b1);
          state_d = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        we    = 1'b1;
        waddr = phys(head_q, idx_q);
        if ($signed(rdata) > key_q) begin
          wdata   = rdata;
          idx_d   = idx_q - 1'b1;
          state_d = S_INS_RD;
        end else begin
          wdata   = key_q;
          cnt_d   = cnt_q + 1'b1;
          state_d = S_RMIN;
        end
      end
      S_RMIN: begin
        re      = 1'b1;
        raddr   = phys(head_q, '0);
        state_d = S_RMAX;
      end
      S_RMAX: begin
        re      = 1'b1;
        raddr   = phys(head_q, cnt_q - 1'b1);
        min_d   = rdata;
        state_d = S_RLAST;
      end
      S_RLAST: begin
        if (load) begin
          if (clr_q) begin
            cnt_d  = '0;
            head_d = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ov_d   = ov_q;
    oe_d   = oe_q;
    omax_d = omax_q;
    omin_d = omin_q;
    odr_d  = odr_q;
    oig_d  = oig_q;
    if (out_acc) begin
      ov_d = 1'b0;
    end
    if (load) begin
      ov_d   = 1'b1;
      oe_d   = (cnt_q == '0);
      omax_d = (cnt_q == '0) ? '0 : rdata;
      omin_d = (cnt_q == '0) ? '0 : min_q;
      odr_d  = drop_q;
      oig_d  = ign_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      head_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      head_q  <= head_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    key_q  <= key_d;
    drop_q <= drop_d;
    ign_q  <= ign_d;
    clr_q  <= clr_d;
    min_q  <= min_d;
    oe_q   <= oe_d;
    omax_q <= omax_d;
    omin_q <= omin_d;
    odr_q  <= odr_d;
    oig_q  <= oig_d;
  end

  depq_mem #(
    .Depth(Capacity),
    .AddrW(AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign out_valid_o      = ov_q;
  assign is_empty_o       = oe_q;
  assign max_value_o      = omax_q;
  assign min_value_o      = omin_q;
  assign insert_dropped_o = odr_q;
  assign delete_ignored_o = oig_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(Capacity))
    else $error("occupancy above capacity");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> !(odr_q && oig_q))
    else $error("dropped and ignored both set");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != S_IDLE))
    else $error("transaction accepted without leaving idle");

  a_no_rw_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && re) |-> 1'b0)
    else $error("read and write in the same cycle");

endmodule

### hw/rtl/depq_mem.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// depq_mem
// value store: one write port, one read port, registered read data
// ---------------------------------------------------------------------------
module depq_mem import depq_pkg::*; #(
  parameter int Depth = DEPQ_CAPACITY,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AddrW-1:0]  raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [Depth];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### tb/sv/depq_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// depq_checker
// watches both channels of the priority queue, keeps its own sorted copy of
// the held values and compares every result transaction field by field
// ---------------------------------------------------------------------------
module depq_checker import depq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic [1:0]               action_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic                     is_empty_i,
  input  logic signed [DATA_W-1:0] max_value_i,
  input  logic signed [DATA_W-1:0] min_value_i,
  input  logic                     insert_dropped_i,
  input  logic                     delete_ignored_i,
  output int                       fail_count_o,
  output int                       pending_o,
  output int                       occupancy_o
);

  typedef struct packed {
    logic                     is_empty;
    logic signed [DATA_W-1:0] max_value;
    logic signed [DATA_W-1:0] min_value;
    logic                     insert_dropped;
    logic                     delete_ignored;
  } queue_result_t;

  logic signed [DATA_W-1:0] held_values[$];
  queue_result_t            expected_results[$];
  int                       fail_count;

  function automatic queue_result_t apply_action(action_e act, logic signed [DATA_W-1:0] val);
    queue_result_t r;
    int            pos;
    r = '0;
    case (act)
      ACT_INSERT: begin
        if (held_values.size() >= DEPQ_CAPACITY) begin
          r.insert_dropped = 1'b1;
        end else begin
          pos = held_values.size();
          while (pos > 0 && held_values[pos-1] > val) pos--;
          held_values.insert(pos, val);
        end
      end
      ACT_DEL_MIN: begin
        if (held_values.size() == 0) r.delete_ignored = 1'b1;
        else void'(held_values.pop_front());
      end
      ACT_DEL_MAX: begin
        if (held_values.size() == 0) r.delete_ignored = 1'b1;
        else void'(held_values.pop_back());
      end
      default: ;
    endcase
    if (held_values.size() == 0) begin
      r.is_empty = 1'b1;
    end else begin
      r.max_value = held_values[held_values.size()-1];
      r.min_value = held_values[0];
    end
    if (act == ACT_FINISH) held_values.delete();
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    queue_result_t got, exp_r;
    if (!rst_ni) begin
      held_values.delete();
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        expected_results.push_back(apply_action(action_e'(action_i), value_i));
      end
      if (out_valid_i && !out_stall_i) begin
        got = '{is_empty_i, max_value_i, min_value_i, insert_dropped_i, delete_ignored_i};
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result transaction: %p", got);
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: expected %p, actual %p", exp_r, got);
          end
        end
      end
    end
  end

  assign fail_count_o = fail_count;
  assign pending_o    = expected_results.size();
  assign occupancy_o  = held_values.size();

endmodule

### tb/sv/double_ended_priority_queue_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// double_ended_priority_queue_top_tb
// directed and random queue actions with random gaps on both channels,
// fill-to-capacity and drain sequences; verdict from the checker's count
// ---------------------------------------------------------------------------
module double_ended_priority_queue_top_tb;
  import depq_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [1:0]               action_i = ACT_FINISH;
  logic signed [DATA_W-1:0] value_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic                     is_empty_o;
  logic signed [DATA_W-1:0] max_value_o, min_value_o;
  logic                     insert_dropped_o, delete_ignored_o;
  int                       fail_count, pending, occupancy;
  int                       idle_cycles;
  bit                       stimulus_done = 1'b0;
  bit                       stall_enable = 1'b1;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  double_ended_priority_queue_top i_dut (.*);

  depq_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .action_i, .value_i,
    .out_valid_i(out_valid_o), .out_stall_i, .is_empty_i(is_empty_o),
    .max_value_i(max_value_o), .min_value_i(min_value_o),
    .insert_dropped_i(insert_dropped_o), .delete_ignored_i(delete_ignored_o),
    .fail_count_o(fail_count), .pending_o(pending), .occupancy_o(occupancy)
  );

  function automatic int gap_length();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  function automatic logic [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      2: return $urandom_range(0, 15) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(action_e act, logic [DATA_W-1:0] val);
    int gap;
    gap = stimulus_done ? 0 : gap_length();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    value_i    <= val;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // receiver stall
  always @(posedge clk_i) begin
    if (stall_enable && $urandom_range(0, 3) == 0) out_stall_i <= 1'b1;
    else out_stall_i <= 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int n;
    idle_cycles = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: empty deletes, extremes, duplicates, finish
    send_item(ACT_DEL_MIN, 32'h0);
    send_item(ACT_DEL_MAX, 32'hFFFF_FFFF);
    send_item(ACT_FINISH, 32'h0);
    send_item(ACT_INSERT, 32'h8000_0000);
    send_item(ACT_INSERT, 32'h7FFF_FFFF);
    send_item(ACT_INSERT, 32'h0);
    send_item(ACT_INSERT, 32'hFFFF_FFFF);
    send_item(ACT_INSERT, 32'h7FFF_FFFF);
    send_item(ACT_INSERT, 32'h5555_5555);
    send_item(ACT_INSERT, 32'hAAAA_AAAA);
    send_item(ACT_DEL_MAX, 32'h0);
    send_item(ACT_DEL_MIN, 32'h0);
    send_item(ACT_DEL_MAX, 32'h0);
    send_item(ACT_FINISH, 32'h0);
    send_item(ACT_DEL_MAX, 32'h0);
    send_item(ACT_INSERT, 32'h1);
    send_item(ACT_DEL_MIN, 32'h0);
    drain();
    // receiver stall off for the fill and drain phase
    stall_enable = 1'b0;
    // fill past capacity, then drain from both ends
    for (int i = 0; i < DEPQ_CAPACITY + 4; i++) send_item(ACT_INSERT, rand_value());
    n = 0;
    while (occupancy > 0 || n < 3) begin
      send_item($urandom_range(0, 1) ? ACT_DEL_MIN : ACT_DEL_MAX, $urandom);
      if (occupancy == 0) n++;
    end
    drain();
    stall_enable = 1'b1;
    // random phase: bursts of inserts and deletes with occasional finish
    for (int i = 0; i < 660; i++) begin
      case ($urandom_range(0, 19))
        0: send_item(ACT_FINISH, $urandom);
        1, 2, 3, 4: send_item(ACT_DEL_MIN, $urandom);
        5, 6, 7, 8: send_item(ACT_DEL_MAX, $urandom);
        default: send_item(ACT_INSERT, rand_value());
      endcase
      if (i == 330) drain();
    end
    in_valid_i <= 1'b0;
    stimulus_done = 1'b1;
    while (pending != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/depq_pkg.sv
hw/rtl/depq_mem.sv
hw/rtl/double_ended_priority_queue_top.sv
tb/sv/depq_checker.sv
tb/sv/double_ended_priority_queue_top_tb.sv
